/* rtl/core/dic_pkg.sv */
// Shared types and constants for the deferred interrupt coalescing drain.
`default_nettype none
package dic_pkg;

    // Default configuration
    localparam int NUM_LINES_DEF   = 64;
    localparam int COUNT_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int LINE_FIELD_W = 6;
    localparam int OUT_COUNT_W  = 32;
    localparam int LEVEL_W      = 8;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    // Input item kinds
    typedef enum logic [1:0] {
        KIND_EVENT   = 2'd0,
        KIND_SAVE    = 2'd1,
        KIND_RESTORE = 2'd2,
        KIND_HANDLER = 2'd3
    } t_kind;

    // Control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INC,
        ST_CHK,
        ST_SCAN,
        ST_READ,
        ST_OUT
    } t_state;

    // Count store access strobes
    typedef struct packed {
        logic rd;
        logic wr;
    } t_cnt_ctl;

endpackage
`default_nettype wire

/* rtl/core/dic_ram.sv */
// Generic simple dual-port RAM with one registered read port.
`default_nettype none
module dic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/core/dic_cnt_store.sv */
// Per-line event count store: RAM plus written bits that make reset read as zero.
`default_nettype none
module dic_cnt_store #(
    parameter int NUM_LINES   = dic_pkg::NUM_LINES_DEF,
    parameter int COUNT_WIDTH = dic_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire dic_pkg::t_cnt_ctl            i_ctl,
    input  wire logic [$clog2(NUM_LINES)-1:0] i_addr,
    input  wire logic [COUNT_WIDTH-1:0]       i_wdata,
    output logic      [COUNT_WIDTH-1:0]       o_rdata
);

    logic [NUM_LINES-1:0]   r_written;
    logic                   r_rd_written;
    logic [COUNT_WIDTH-1:0] w_ram_rdata;

    // Track which entries hold a value since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_ctl.wr) begin
                r_written[i_addr] <= 1'b1;
            end
            if (i_ctl.rd) begin
                r_rd_written <= r_written[i_addr];
            end
        end
    end

    dic_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_LINES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr),
        .i_waddr (i_addr),
        .i_wdata (i_wdata),
        .i_re    (i_ctl.rd),
        .i_raddr (i_addr),
        .o_rdata (w_ram_rdata)
    );

    // Never-written entries read as zero
    assign o_rdata = r_rd_written ? w_ram_rdata : '0;

endmodule
`default_nettype wire

/* rtl/core/deferred_irq_coalescing_drain.sv */
// Top level: interrupt coalescer with deferred, highest-line-first draining.
// An event or handler update reads the count, then writes it back or does the pending
// check. A drain picks a line, reads its count and presents the call result for each
// owed line, or one no-call result when no pending line has a handler; a stalled
// result holds. One item is in work at a time. Synchronous active-low reset clears
// pending, handler, level and count written bits; no memory clearing pass is needed.
`default_nettype none
module deferred_irq_coalescing_drain #(
    parameter int NUM_LINES   = dic_pkg::NUM_LINES_DEF,
    parameter int COUNT_WIDTH = dic_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Input channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [1:0]                       i_kind,
    input  wire logic [dic_pkg::LINE_FIELD_W-1:0] i_irq_number,
    input  wire logic                             i_handler_present,
    // Output channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic                                  o_call_valid,
    output logic      [dic_pkg::LINE_FIELD_W-1:0] o_served_line,
    output logic      [dic_pkg::OUT_COUNT_W-1:0]  o_event_count,
    output logic                                  o_schedule_request,
    output logic                                  o_last
);

    localparam int LINE_W = $clog2(NUM_LINES);

    dic_pkg::t_state r_state, n_state;

    logic [NUM_LINES-1:0]           r_pending, n_pending;
    logic [NUM_LINES-1:0]           r_handler, n_handler;
    logic [NUM_LINES-1:0]           r_todo, n_todo;
    logic [dic_pkg::LEVEL_W-1:0]    r_level, n_level;
    logic [LINE_W-1:0]              r_line, n_line;

    logic                           r_out_call, n_out_call;
    logic [dic_pkg::LINE_FIELD_W-1:0] r_out_line, n_out_line;
    logic [dic_pkg::OUT_COUNT_W-1:0]  r_out_count, n_out_count;
    logic                           r_out_last, n_out_last;

    dic_pkg::t_cnt_ctl              w_ctl;
    logic [LINE_W-1:0]              w_addr;
    logic [COUNT_WIDTH-1:0]         w_wdata;
    logic [COUNT_WIDTH-1:0]         w_rdata;
    logic [COUNT_WIDTH-1:0]         w_cnt_inc;

    logic                           w_in_acc;
    logic                           w_out_acc;
    logic                           w_in_range;
    logic [LINE_W-1:0]              w_in_line;
    dic_pkg::t_kind                 w_kind;
    logic [LINE_W-1:0]              w_top_line;
    logic                           w_restore_drain;

    // Take input beats only when idle
    assign o_in_stall = (r_state != dic_pkg::ST_IDLE);

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_acc  = o_out_valid && !i_out_stall;
    assign w_kind     = dic_pkg::t_kind'(i_kind);
    assign w_in_line  = i_irq_number[LINE_W-1:0];
    assign w_in_range = ({1'b0, i_irq_number} < (dic_pkg::LINE_FIELD_W + 1)'(NUM_LINES));
    assign w_restore_drain = (r_level == dic_pkg::LEVEL_W'(1)) && (r_pending != '0);

    // Saturating count increment
    assign w_cnt_inc = (&w_rdata) ? w_rdata : w_rdata + COUNT_WIDTH'(1);

    // Find highest line still owed a call
    always_comb begin
        w_top_line = '0;
        for (int i = 0; i < NUM_LINES; i++) begin
            if (r_todo[i]) begin
                w_top_line = LINE_W'(i);
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dic_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    unique case (w_kind)
                        dic_pkg::KIND_EVENT: begin
                            if (w_in_range) n_state = dic_pkg::ST_INC;
                        end
                        dic_pkg::KIND_HANDLER: begin
                            if (w_in_range) n_state = dic_pkg::ST_CHK;
                        end
                        dic_pkg::KIND_RESTORE: begin
                            if (w_restore_drain) n_state = dic_pkg::ST_SCAN;
                        end
                        dic_pkg::KIND_SAVE: begin
                            n_state = dic_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            dic_pkg::ST_INC: begin
                n_state = (r_level == '0) ? dic_pkg::ST_SCAN : dic_pkg::ST_IDLE;
            end
            dic_pkg::ST_CHK: begin
                n_state = dic_pkg::ST_IDLE;
            end
            dic_pkg::ST_SCAN: begin
                n_state = (r_todo == '0) ? dic_pkg::ST_OUT : dic_pkg::ST_READ;
            end
            dic_pkg::ST_READ: begin
                n_state = dic_pkg::ST_OUT;
            end
            dic_pkg::ST_OUT: begin
                if (w_out_acc) begin
                    n_state = r_out_last ? dic_pkg::ST_IDLE : dic_pkg::ST_SCAN;
                end
            end
            default: begin
                n_state = dic_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and count memory control
    always_comb begin
        n_pending   = r_pending;
        n_handler   = r_handler;
        n_todo      = r_todo;
        n_level     = r_level;
        n_line      = r_line;
        n_out_call  = r_out_call;
        n_out_line  = r_out_line;
        n_out_count = r_out_count;
        n_out_last  = r_out_last;
        w_ctl       = '0;
        w_addr      = r_line;
        w_wdata     = '0;
        o_out_valid = 1'b0;

        unique case (r_state)
            dic_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    unique case (w_kind)
                        dic_pkg::KIND_EVENT: begin
                            if (w_in_range) begin
                                n_pending[w_in_line] = 1'b1;
                                n_line               = w_in_line;
                                w_addr               = w_in_line;
                                w_ctl.rd             = 1'b1;
                            end
                        end
                        dic_pkg::KIND_HANDLER: begin
                            if (w_in_range) begin
                                n_handler[w_in_line] = i_handler_present;
                                n_line               = w_in_line;
                                w_addr               = w_in_line;
                                w_ctl.rd             = 1'b1;
                            end
                        end
                        dic_pkg::KIND_SAVE: begin
                            if (r_level != dic_pkg::LEVEL_MAX) begin
                                n_level = r_level + dic_pkg::LEVEL_W'(1);
                            end
                        end
                        dic_pkg::KIND_RESTORE: begin
                            if (w_restore_drain) begin
                                // Start drain: snapshot handled lines, drop all pending
                                n_level   = '0;
                                n_todo    = r_pending & r_handler;
                                n_pending = '0;
                            end else if (r_level != '0) begin
                                n_level = r_level - dic_pkg::LEVEL_W'(1);
                            end
                        end
                    endcase
                end
            end
            dic_pkg::ST_INC: begin
                // Write back bumped count, drain at level zero
                w_ctl.wr = 1'b1;
                w_wdata  = w_cnt_inc;
                if (r_level == '0) begin
                    n_todo    = r_pending & r_handler;
                    n_pending = '0;
                end
            end
            dic_pkg::ST_CHK: begin
                if (w_rdata != '0) begin
                    n_pending[r_line] = 1'b1;
                end
            end
            dic_pkg::ST_SCAN: begin
                if (r_todo == '0) begin
                    // Drain with no call
                    n_out_call  = 1'b0;
                    n_out_line  = '0;
                    n_out_count = '0;
                    n_out_last  = 1'b1;
                end else begin
                    w_ctl.rd           = 1'b1;
                    w_addr             = w_top_line;
                    n_line             = w_top_line;
                    n_todo[w_top_line] = 1'b0;
                end
            end
            dic_pkg::ST_READ: begin
                // Hand count out and clear it
                w_ctl.wr    = 1'b1;
                w_wdata     = '0;
                n_out_call  = 1'b1;
                n_out_line  = dic_pkg::LINE_FIELD_W'(r_line);
                n_out_count = dic_pkg::OUT_COUNT_W'(w_rdata);
                n_out_last  = (r_todo == '0);
            end
            dic_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_out_valid = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dic_pkg::ST_IDLE;
            r_pending <= '0;
            r_handler <= '0;
            r_todo    <= '0;
            r_level   <= '0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_handler <= n_handler;
            r_todo    <= n_todo;
            r_level   <= n_level;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_line      <= n_line;
        r_out_call  <= n_out_call;
        r_out_line  <= n_out_line;
        r_out_count <= n_out_count;
        r_out_last  <= n_out_last;
    end

    dic_cnt_store #(
        .NUM_LINES   (NUM_LINES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    assign o_call_valid       = r_out_call;
    assign o_served_line      = r_out_line;
    assign o_event_count      = r_out_count;
    assign o_schedule_request = r_out_last;
    assign o_last             = r_out_last;

endmodule
`default_nettype wire

/* rtl/core/dic_checker.sv */
// Port-level checker for the coalescing drain, bound to the top level.
`default_nettype none
module dic_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             o_in_stall,
    input wire logic                             o_out_valid,
    input wire logic                             i_out_stall,
    input wire logic                             o_call_valid,
    input wire logic [dic_pkg::LINE_FIELD_W-1:0] o_served_line,
    input wire logic [dic_pkg::OUT_COUNT_W-1:0]  o_event_count,
    input wire logic                             o_schedule_request,
    input wire logic                             o_last
);

    // No input beat is taken while a result waits
    a_stall_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while result pending");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_call_valid)
            && $stable(o_served_line) && $stable(o_event_count) && $stable(o_last))
        else $error("stalled result changed");

    // Schedule request rides on the final beat of a drain
    a_sched_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_schedule_request == o_last))
        else $error("schedule request not on last beat");

    // A no-call result is a lone, empty, final beat
    a_no_call: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_call_valid |-> o_last && (o_served_line == '0)
            && (o_event_count == '0))
        else $error("malformed no-call result");

    // After a non-final beat the next line is being fetched
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |=> !o_out_valid && o_in_stall)
        else $error("drain continuation malformed");

endmodule

bind deferred_irq_coalescing_drain dic_checker u_dic_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_call_valid       (o_call_valid),
    .o_served_line      (o_served_line),
    .o_event_count      (o_event_count),
    .o_schedule_request (o_schedule_request),
    .o_last             (o_last)
);
`default_nettype wire
